@@ rtl/core/xtbs_pkg.sv @@
// Shared types, codes, key table and helper functions of the XOR-table byte scrambler.
`default_nettype none

package xtbs_pkg;

    // Key table geometry
    localparam int KEY_LENGTH = 77;
    localparam int KEY_IDX_W  = $clog2(KEY_LENGTH);

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ODD      = 2'd1;
    localparam logic [1:0] STATUS_BAD_HEX  = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    // Register indexes on the configuration port
    localparam logic REG_DIRECTION = 1'b0;

    // Direction codes
    localparam logic DIR_SCRAMBLE   = 1'b0;
    localparam logic DIR_UNSCRAMBLE = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_EMIT,
        ST_ERROR
    } state_t;

    // Fixed key table
    localparam logic [7:0] KEY_ROM [KEY_LENGTH] = '{
        8'd45, 8'd79, 8'd68, 8'd73, 8'd70, 8'd73, 8'd69, 8'd68, 8'd38, 8'd87, 8'd48,
        8'd82, 8'd79, 8'd80, 8'd69, 8'd82, 8'd84, 8'd89, 8'd51, 8'd72, 8'd69, 8'd69,
        8'd84, 8'd55, 8'd73, 8'd84, 8'd72, 8'd47, 8'd43, 8'd52, 8'd72, 8'd69, 8'd51,
        8'd72, 8'd69, 8'd69, 8'd84, 8'd41, 8'd36, 8'd51, 8'd63, 8'd44, 8'd36, 8'd33,
        8'd48, 8'd63, 8'd33, 8'd53, 8'd63, 8'd48, 8'd50, 8'd47, 8'd48, 8'd37, 8'd50,
        8'd52, 8'd41, 8'd37, 8'd51, 8'd46, 8'd53, 8'd44, 8'd44, 8'd16, 8'd38, 8'd55,
        8'd63, 8'd55, 8'd48, 8'd63, 8'd47, 8'd34, 8'd42, 8'd37, 8'd35, 8'd52, 8'd51
    };

    // Decode an ASCII hex character; bit 4 set marks an invalid character
    function automatic logic [4:0] hex_value(input logic [7:0] ch);
        logic [4:0] v;
        v = 5'h10;
        if (ch >= 8'd48 && ch <= 8'd57) begin
            v = 5'(ch - 8'd48);
        end else if (ch >= 8'd97 && ch <= 8'd102) begin
            v = 5'(ch - 8'd87);
        end else if (ch >= 8'd65 && ch <= 8'd70) begin
            v = 5'(ch - 8'd55);
        end
        return v;
    endfunction

    // Encode a nibble as a lowercase ASCII hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] d;
        d = (n < 4'd10) ? (8'd48 + {4'h0, n}) : (8'd87 + {4'h0, n});
        return d;
    endfunction

    // Translate one byte against the key entry at the given index
    function automatic logic [7:0] translate(input logic [7:0] c,
                                             input logic [KEY_IDX_W-1:0] idx);
        logic [7:0] cm;
        logic [7:0] v;
        cm = (c == 8'hFF) ? 8'h00 : c;
        v  = cm ^ KEY_ROM[idx];
        return (v == 8'h00) ? 8'hFF : v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/xor_table_byte_scrambler_core.sv @@
// Top level of the XOR-table byte scrambler: message buffer, emission pipeline, config port.
//
// Usage: set direction over the APB port while idle (0 scrambles bytes into hex pairs,
// 1 unscrambles hex text into bytes); a write also discards any partial message.
// Stream a message into the s_ channel one transaction per cycle, s_tlast on its final
// item. Bytes (or completed hex pairs) are written into a buffer of MAX_BYTES entries.
// After the final item the block walks the buffer one entry per cycle while the receiver
// keeps up, last stored byte first, and emits one m_ transaction per byte, m_tlast on the
// final one. An odd hex length, a bad hex character or a message longer than the buffer
// yields a single transaction carrying the status in m_tuser instead.
// After the edge that accepts the final input item, each result passes the read stage, then
// the output register, before m_tvalid rises. Throughput: one input item per cycle while
// loading, then one result per cycle while emitting and the receiver keeps up, set by the
// single read port of the buffer; s_tready stays low until the last buffer read (or the
// error result) of the message has issued. A stalled receiver freezes the read pipeline and
// the buffer read data in place; nothing is lost. Reset clears the direction, the partial
// message and all valid bits; the buffer contents are not cleared and need no clearing pass.
`default_nettype none

module xor_table_byte_scrambler_core #(
    parameter int MAX_BYTES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // last_in
    // Result stream
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [23:0] m_tdata,   // [15:0] hex_pair, [23:16] data_byte
    output      logic [1:0]  m_tuser,   // [1:0] status
    output      logic        m_tlast,   // last_out
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);

    // Control registers
    xtbs_pkg::state_t state_reg, state_next;
    logic          direction_reg, direction_next;
    logic [CW-1:0] fill_count_reg, fill_count_next;
    logic [3:0]    high_nibble_reg, high_nibble_next;
    logic          nibble_phase_reg, nibble_phase_next;
    logic [1:0]    error_code_reg, error_code_next;
    logic [1:0]    err_status_reg, err_status_next;
    logic [AW-1:0] rev_reg, rev_next;
    logic [AW-1:0] k_reg, k_next;

    // Read stage (data sits in the RAM output register)
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_err_reg, s1_err_next;
    logic [1:0]    s1_status_reg, s1_status_next;
    logic [AW-1:0] s1_key_idx_reg, s1_key_idx_next;
    logic          s1_last_reg, s1_last_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [23:0]   out_data_reg, out_data_next;
    logic [1:0]    out_user_reg, out_user_next;
    logic          out_last_reg, out_last_next;

    // RAM ports
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    // Handshake and pipeline flow
    logic          in_accept;
    logic          cfg_write;
    logic          out_free;
    logic          s1_adv;
    logic          s1_free;
    logic          issue_rd;
    logic          issue_err;

    // Load-side helpers
    logic [4:0]    hex_val;
    logic [3:0]    nib;
    logic          push_en;
    logic [7:0]    push_data;
    logic [1:0]    err_pre;
    logic [1:0]    final_status;

    // Translation of the read stage
    logic [7:0]    xlat;

    xtbs_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Handshakes
    assign s_tready  = (state_reg == xtbs_pkg::ST_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == xtbs_pkg::REG_DIRECTION);
    assign prdata    = (paddr[2] == xtbs_pkg::REG_DIRECTION) ? {31'h0, direction_reg} : 32'h0;

    // Pipeline flow: output register, then read stage, then issue
    assign out_free  = !out_valid_reg || m_tready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || s1_adv;
    assign issue_rd  = (state_reg == xtbs_pkg::ST_EMIT) && s1_free;
    assign issue_err = (state_reg == xtbs_pkg::ST_ERROR) && s1_free;

    assign ram_rd_en   = issue_rd;
    assign ram_rd_addr = rev_reg;

    // Translate the byte waiting in the read stage
    assign xlat = xtbs_pkg::translate(ram_rd_data,
                                      xtbs_pkg::KEY_IDX_W'(s1_key_idx_reg));

    // Next state and load path
    always_comb begin
        state_next        = state_reg;
        direction_next    = direction_reg;
        fill_count_next   = fill_count_reg;
        high_nibble_next  = high_nibble_reg;
        nibble_phase_next = nibble_phase_reg;
        error_code_next   = error_code_reg;
        err_status_next   = err_status_reg;
        rev_next          = rev_reg;
        k_next            = k_reg;

        hex_val      = xtbs_pkg::hex_value(s_tdata);
        nib          = hex_val[4] ? 4'h0 : hex_val[3:0];
        push_en      = 1'b0;
        push_data    = s_tdata;
        err_pre      = error_code_reg;
        final_status = xtbs_pkg::STATUS_OK;

        ram_wr_en   = 1'b0;
        ram_wr_addr = fill_count_reg[AW-1:0];
        ram_wr_data = push_data;

        unique case (state_reg)
            xtbs_pkg::ST_LOAD: begin
                if (in_accept) begin
                    // Form the byte to store
                    if (direction_reg == xtbs_pkg::DIR_SCRAMBLE) begin
                        push_en = 1'b1;
                    end else begin
                        if (hex_val[4]) begin
                            err_pre = xtbs_pkg::STATUS_BAD_HEX;
                        end
                        if (!nibble_phase_reg) begin
                            high_nibble_next  = nib;
                            nibble_phase_next = 1'b1;
                        end else begin
                            nibble_phase_next = 1'b0;
                            push_en           = 1'b1;
                            push_data         = {high_nibble_reg, nib};
                        end
                    end
                    error_code_next = err_pre;
                    ram_wr_data     = push_data;

                    // Store it, or flag overflow once
                    if (push_en) begin
                        if (fill_count_reg < CW'(MAX_BYTES)) begin
                            ram_wr_en       = 1'b1;
                            fill_count_next = fill_count_reg + CW'(1);
                        end else if (err_pre == xtbs_pkg::STATUS_OK) begin
                            error_code_next = xtbs_pkg::STATUS_OVERFLOW;
                        end
                    end

                    // End of message: pick error or emission
                    if (s_tlast) begin
                        final_status = error_code_next;
                        if (direction_reg == xtbs_pkg::DIR_UNSCRAMBLE && nibble_phase_next) begin
                            final_status = xtbs_pkg::STATUS_ODD;
                        end
                        if (final_status != xtbs_pkg::STATUS_OK) begin
                            err_status_next = final_status;
                            state_next      = xtbs_pkg::ST_ERROR;
                        end else if (fill_count_next != '0) begin
                            rev_next   = AW'(fill_count_next - CW'(1));
                            k_next     = '0;
                            state_next = xtbs_pkg::ST_EMIT;
                        end
                        fill_count_next   = '0;
                        high_nibble_next  = 4'h0;
                        nibble_phase_next = 1'b0;
                        error_code_next   = xtbs_pkg::STATUS_OK;
                    end
                end
            end
            xtbs_pkg::ST_EMIT: begin
                // Walk the buffer from the last stored byte down
                if (issue_rd) begin
                    rev_next = rev_reg - AW'(1);
                    k_next   = k_reg + AW'(1);
                    if (rev_reg == '0) begin
                        state_next = xtbs_pkg::ST_LOAD;
                    end
                end
            end
            xtbs_pkg::ST_ERROR: begin
                if (issue_err) begin
                    state_next = xtbs_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = xtbs_pkg::ST_LOAD;
            end
        endcase

        // Direction write drops the partial message
        if (cfg_write) begin
            direction_next    = pwdata[0];
            fill_count_next   = '0;
            high_nibble_next  = 4'h0;
            nibble_phase_next = 1'b0;
            error_code_next   = xtbs_pkg::STATUS_OK;
        end
    end

    // Read stage and output register
    always_comb begin
        s1_valid_next   = s1_valid_reg;
        s1_err_next     = s1_err_reg;
        s1_status_next  = s1_status_reg;
        s1_key_idx_next = s1_key_idx_reg;
        s1_last_next    = s1_last_reg;

        if (issue_rd) begin
            s1_valid_next   = 1'b1;
            s1_err_next     = 1'b0;
            s1_status_next  = xtbs_pkg::STATUS_OK;
            s1_key_idx_next = (direction_reg == xtbs_pkg::DIR_SCRAMBLE) ? rev_reg : k_reg;
            s1_last_next    = (rev_reg == '0);
        end else if (issue_err) begin
            s1_valid_next   = 1'b1;
            s1_err_next     = 1'b1;
            s1_status_next  = err_status_reg;
            s1_last_next    = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;

        if (s1_adv) begin
            out_valid_next = 1'b1;
            out_user_next  = s1_status_reg;
            out_last_next  = s1_last_reg;
            if (s1_err_reg) begin
                out_data_next = 24'h0;
            end else if (direction_reg == xtbs_pkg::DIR_SCRAMBLE) begin
                out_data_next = {8'h00, xtbs_pkg::hex_digit(xlat[7:4]),
                                 xtbs_pkg::hex_digit(xlat[3:0])};
            end else begin
                out_data_next = {xlat, 16'h0000};
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= xtbs_pkg::ST_LOAD;
            direction_reg    <= xtbs_pkg::DIR_SCRAMBLE;
            fill_count_reg   <= '0;
            high_nibble_reg  <= 4'h0;
            nibble_phase_reg <= 1'b0;
            error_code_reg   <= xtbs_pkg::STATUS_OK;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            direction_reg    <= direction_next;
            fill_count_reg   <= fill_count_next;
            high_nibble_reg  <= high_nibble_next;
            nibble_phase_reg <= nibble_phase_next;
            error_code_reg   <= error_code_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        err_status_reg <= err_status_next;
        rev_reg        <= rev_next;
        k_reg          <= k_next;
        s1_err_reg     <= s1_err_next;
        s1_status_reg  <= s1_status_next;
        s1_key_idx_reg <= s1_key_idx_next;
        s1_last_reg    <= s1_last_next;
        out_data_reg   <= out_data_next;
        out_user_reg   <= out_user_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // A stalled read stage keeps its valid bit and its buffer data
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(ram_rd_data))
        else $error("read stage lost data under stall");

    // Error results always close the message
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != xtbs_pkg::STATUS_OK) |-> m_tlast)
        else $error("error result without last flag");

    // Buffer is never written while it is being walked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != xtbs_pkg::ST_LOAD) |-> !ram_wr_en)
        else $error("buffer write during emission");

    // Fill count never passes the buffer depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CW'(MAX_BYTES))
        else $error("fill count beyond buffer depth");

endmodule

`default_nettype wire

@@ rtl/core/xtbs_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module xtbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the data while no read is issued
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ verif/xor_table_byte_scrambler_core_tb.sv @@
// Self-checking testbench for the XOR-table byte scrambler core: directed and random messages.
`timescale 1ns / 1ps

module xor_table_byte_scrambler_core_tb;

    localparam int BUF_DEPTH     = 64;
    localparam int RANDOM_ITEMS  = 245;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 500000;

    // Byte addresses on the configuration port
    localparam logic [2:0] DIRECTION_ADDR = {xtbs_pkg::REG_DIRECTION, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR  = {~xtbs_pkg::REG_DIRECTION, 2'b00};

    typedef struct packed {
        logic [15:0] hex_pair;
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic        last_out;
    } result_t;

    // Tracks the message in flight and holds the results it must produce
    class scramble_tracker;
        result_t    expected_results[$];
        logic [7:0] stored_bytes[BUF_DEPTH];
        int         fill;
        logic [3:0] pending_high;
        bit         half_pair;
        logic [1:0] held_status;
        logic       direction;
        int         failures;

        function new();
            direction = xtbs_pkg::DIR_SCRAMBLE;
            failures  = 0;
            clear_message();
        endfunction

        function void clear_message();
            fill         = 0;
            pending_high = 4'h0;
            half_pair    = 1'b0;
            held_status  = xtbs_pkg::STATUS_OK;
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            failures++;
        endfunction

        function string describe(result_t r);
            return $sformatf("hex=%h data=%h status=%0d last=%0d",
                             r.hex_pair, r.data_byte, r.status, r.last_out);
        endfunction

        // Any write to the direction register drops the partial message
        function void write_reg(logic [2:0] addr, logic [31:0] value);
            if (addr == DIRECTION_ADDR) begin
                direction = value[0];
                clear_message();
            end
        endfunction

        // Nibble value of an ASCII hex character; bit 4 flags a non-hex character
        function logic [4:0] nibble_of(logic [7:0] ch);
            if (ch >= "0" && ch <= "9") return {1'b0, 4'(ch - "0")};
            if (ch >= "a" && ch <= "f") return {1'b0, 4'(ch - "a" + 8'd10)};
            if (ch >= "A" && ch <= "F") return {1'b0, 4'(ch - "A" + 8'd10)};
            return 5'h10;
        endfunction

        function logic [7:0] ascii_digit(logic [3:0] n);
            return (n < 4'd10) ? 8'("0") + 8'(n) : 8'("a") + 8'(n) - 8'd10;
        endfunction

        // Fold modulo 255, xor with the key entry, map zero to 255
        function logic [7:0] keyed(int pos, logic [7:0] c);
            logic [7:0] folded;
            logic [7:0] v;
            folded = (c == 8'hFF) ? 8'h00 : c;
            v = folded ^ xtbs_pkg::KEY_ROM[pos % xtbs_pkg::KEY_LENGTH];
            return (v == 8'h00) ? 8'hFF : v;
        endfunction

        function void store_byte(logic [7:0] b);
            if (fill < BUF_DEPTH) begin
                stored_bytes[fill] = b;
                fill++;
            end else if (held_status == xtbs_pkg::STATUS_OK) begin
                held_status = xtbs_pkg::STATUS_OVERFLOW;
            end
        endfunction

        // Account for one accepted input transaction
        function void note_item(logic [7:0] ch, logic last);
            logic [4:0] nib;
            logic [1:0] st;
            logic [7:0] t;
            result_t    r;
            int         src;
            if (direction == xtbs_pkg::DIR_SCRAMBLE) begin
                store_byte(ch);
            end else begin
                nib = nibble_of(ch);
                if (nib[4]) begin
                    held_status = xtbs_pkg::STATUS_BAD_HEX;
                    nib = 5'h00;
                end
                if (!half_pair) begin
                    pending_high = nib[3:0];
                    half_pair    = 1'b1;
                end else begin
                    half_pair = 1'b0;
                    store_byte({pending_high, nib[3:0]});
                end
            end
            if (!last) return;

            st = held_status;
            if (direction == xtbs_pkg::DIR_UNSCRAMBLE && half_pair) st = xtbs_pkg::STATUS_ODD;
            if (st != xtbs_pkg::STATUS_OK) begin
                r          = '0;
                r.status   = st;
                r.last_out = 1'b1;
                expected_results.push_back(r);
            end else begin
                // Walk the buffer from the last stored byte to the first
                for (int k = 0; k < fill; k++) begin
                    src = fill - 1 - k;
                    r   = '0;
                    if (direction == xtbs_pkg::DIR_SCRAMBLE) begin
                        t = keyed(src, stored_bytes[src]);
                        r.hex_pair = {ascii_digit(t[7:4]), ascii_digit(t[3:0])};
                    end else begin
                        r.data_byte = keyed(k, stored_bytes[src]);
                    end
                    r.last_out = (k == fill - 1);
                    expected_results.push_back(r);
                end
            end
            clear_message();
        endfunction

        // Compare one accepted result transaction with the oldest expectation
        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                report({"unexpected result: ", describe(got)});
            end else begin
                want = expected_results.pop_front();
                if (got !== want)
                    report({"expected ", describe(want), ", got ", describe(got)});
            end
        endfunction

        function void close_out();
            if (expected_results.size() != 0)
                report($sformatf("%0d expected results never arrived",
                                 expected_results.size()));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        s_tlast;   // last_in
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [15:0] hex_pair, [23:16] data_byte
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;   // last_out
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    scramble_tracker tracker = new();
    logic [7:0]      message_chars[$];
    int              items_sent  = 0;
    int              ready_run   = 0;
    int              cycle_count = 0;

    xor_table_byte_scrambler_core #(
        .MAX_BYTES(BUF_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stall the result channel at random: mostly short stalls, a few long ones
    always @(posedge aclk) begin
        int pick;
        if (ready_run == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                m_tready  <= 1'b1;
                ready_run <= $urandom_range(1, 40);
            end else if (pick < 9) begin
                m_tready  <= 1'b0;
                ready_run <= $urandom_range(1, 3);
            end else begin
                m_tready  <= 1'b0;
                ready_run <= $urandom_range(10, 40);
            end
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    // Observe both channels at each edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_item(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                tracker.check_result({m_tdata[15:0], m_tdata[23:16], m_tuser, m_tlast});
        end
    end

    // Send message_chars, one transaction each, with random gaps unless no_gaps
    task automatic send_message(input bit ends, input bit no_gaps);
        int gap;
        int pick;
        for (int k = 0; k < message_chars.size(); k++) begin
            pick = $urandom_range(0, 99);
            if (no_gaps || pick < 60) gap = 0;
            else if (pick < 92)       gap = $urandom_range(1, 3);
            else                      gap = $urandom_range(8, 25);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= message_chars[k];
            s_tlast  <= ends && (k == message_chars.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            items_sent++;
        end
    endtask

    // Hold the sender until every expected result is in, then let the pipeline settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
        while (tracker.expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(addr, value);
    endtask

    task automatic apb_read_direction();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= DIRECTION_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== 32'(tracker.direction))
            tracker.report($sformatf("direction read back %h, expected %0d",
                                     prdata, tracker.direction));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int         random_start;
        int         msg_index;
        int         n_bytes;
        int         n_chars;
        int         pick;
        int         nib;
        int         bad_pos;
        bit         odd;
        bit         bad;
        bit         overflow;
        logic [7:0] c;
        logic [4:0] char_val;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 3'd0;
        pwdata   <= 32'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Scramble after reset: key-cancelling byte, 0xFF folding to zero, extremes
        apb_read_direction();
        message_chars = '{8'h2D, 8'hFF, 8'h00, 8'h80, 8'h7F};
        send_message(1'b1, 1'b0);

        // Unscramble: every digit class, both cases
        wait_drained();
        apb_write(DIRECTION_ADDR, {31'd0, xtbs_pkg::DIR_UNSCRAMBLE});
        apb_read_direction();
        message_chars = '{"0", "9", "a", "f", "A", "F"};
        send_message(1'b1, 1'b0);

        // Odd length, bad character, and odd length winning over a bad character
        message_chars = '{"a", "b", "c"};
        send_message(1'b1, 1'b1);
        message_chars = '{"g", "1"};
        send_message(1'b1, 1'b0);
        message_chars = '{"/"};
        send_message(1'b1, 1'b0);

        // A direction write drops the partial message
        message_chars = '{"1", "2"};
        send_message(1'b0, 1'b0);
        wait_drained();
        apb_write(DIRECTION_ADDR, {31'd0, xtbs_pkg::DIR_UNSCRAMBLE});
        message_chars = '{"3", "4"};
        send_message(1'b1, 1'b0);

        // A write to an unmapped register leaves the partial message alone
        message_chars = '{"5"};
        send_message(1'b0, 1'b0);
        wait_drained();
        apb_write(UNMAPPED_ADDR, 32'd0);
        apb_read_direction();
        message_chars = '{"6"};
        send_message(1'b1, 1'b0);

        // Random messages: mostly well-formed, some odd, bad or overflowing
        random_start = items_sent;
        msg_index    = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (msg_index == 0 || $urandom_range(0, 4) == 0) begin
                wait_drained();
                apb_write(DIRECTION_ADDR, $urandom());
                if ($urandom_range(0, 1) == 1) apb_read_direction();
            end else if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end

            pick = $urandom_range(0, 99);
            if (msg_index == 3)      n_bytes = BUF_DEPTH + 2;
            else if (msg_index == 6) n_bytes = BUF_DEPTH;
            else if (pick < 80)      n_bytes = $urandom_range(1, 8);
            else if (pick < 95)      n_bytes = $urandom_range(9, BUF_DEPTH);
            else                     n_bytes = $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 3);
            overflow = (n_bytes > BUF_DEPTH);

            message_chars.delete();
            if (tracker.direction == xtbs_pkg::DIR_SCRAMBLE) begin
                for (int k = 0; k < n_bytes; k++)
                    message_chars.push_back(8'($urandom_range(0, 255)));
            end else begin
                odd = ($urandom_range(0, 9) == 0);
                bad = ($urandom_range(0, 9) == 0) || (overflow && $urandom_range(0, 1) == 1);
                n_chars = 2 * n_bytes - (odd ? 1 : 0);
                for (int k = 0; k < n_chars; k++) begin
                    nib = $urandom_range(0, 15);
                    if (nib < 10) c = 8'("0") + 8'(nib);
                    else c = ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(nib - 10);
                    message_chars.push_back(c);
                end
                // Place a bad character late in overflowing messages half the time
                if (bad) begin
                    if (overflow && $urandom_range(0, 1) == 1) bad_pos = n_chars - 1;
                    else bad_pos = $urandom_range(0, n_chars - 1);
                    do begin
                        c        = 8'($urandom_range(0, 255));
                        char_val = tracker.nibble_of(c);
                    end while (!char_val[4]);
                    message_chars[bad_pos] = c;
                end
            end
            send_message(1'b1, $urandom_range(0, 3) == 0);
            msg_index++;
        end

        wait_drained();
        tracker.close_out();
        if (tracker.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
